// ----- sv/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define BFFA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off during reset.
`define BFFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/bffa_pkg.sv -----
// Package for the first-fit block allocator: widths, codes and the scan control struct.
// No dependencies.
package bffa_pkg;
	localparam int POOL_BLOCKS_DEF = 1024;
	localparam int BLOCK_BYTES_DEF = 16;
	localparam int CELL_W = 8;          // map bits held by one cell
	localparam int BND_W = 18;          // width of block indices and range bounds
	localparam int IDX_W = 10;
	localparam int BYTES_W = 15;
	localparam int NEED_W = 16;
	localparam int ONES_W = 4;
	localparam logic [BYTES_W-1:0] FIELD_MAX = 15'h7fff;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_CLR  = 2'd2;
	localparam logic [1:0] OP_ZERO = 2'd3;

	typedef struct packed {
		logic             apply;   // 0: search pass, 1: update pass
		logic [1:0]       op;
		logic [BND_W-1:0] lo;
		logic [BND_W-1:0] hi;
	} scan_ctl_t;
endpackage

// ----- sv/bitmap_first_fit_block_allocator_top.sv -----
// Top level of the bitmap first-fit block allocator: cell ring, scanner, rounding, control.
// Depends on bffa_pkg, bffa_cell, bffa_scan and assert_macros.svh.
//
// A request is taken when start is high and busy is low; one result follows, shown for a
// single cycle with done high, and it cannot be held off. The use map lives in a ring of
// 8-bit cells that rotates one word per cycle during a pass, past a scanner, so every pass
// over the map walks all NW = ceil(POOL_BLOCKS/8) cells (128 at 1024 blocks). A request
// first rounds the byte size up to blocks in S_DIV, a multiply by a constant reciprocal
// that is exact over the whole byte range. An allocate of a nonzero size then makes a
// search pass and an update pass; a zero-size allocate, free, clear and query make the
// update pass only. The update pass also counts used blocks. S_FIN then forms the byte
// totals, and the result shows in the cycle after it. busy falls in the result cycle,
// so the next request can be taken at the edge that ends it. Reset empties the map at
// once; no clearing pass. Pad bits past the pool end (when POOL_BLOCKS is not a
// multiple of eight) are never handed out.
module bitmap_first_fit_block_allocator_top import bffa_pkg::*; #(
	parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [BYTES_W-1:0] request_bytes,
	input  logic [IDX_W-1:0]   start_block,
	output logic               done,
	output logic [IDX_W-1:0]   grant_block,
	output logic               ok,
	output logic [BYTES_W-1:0] allocated_bytes,
	output logic [BYTES_W-1:0] requested_total
);
	`include "assert_macros.svh"

	localparam int NW  = (POOL_BLOCKS + CELL_W - 1) / CELL_W;   // cells in the ring
	localparam int WCW = (NW > 1) ? $clog2(NW) : 1;
	localparam int CW  = $clog2(POOL_BLOCKS + 1);
	localparam int PW  = CW + $clog2(BLOCK_BYTES + 1);

	// round-up division by the block size: floor(n * M / 2^S), exact for n < 2^NEED_W
	localparam int     DIV_S = NEED_W + $clog2(BLOCK_BYTES);
	localparam longint DIV_M = ((longint'(1) << DIV_S) + longint'(BLOCK_BYTES) - 1) /
		longint'(BLOCK_BYTES);
	localparam int     MW    = NEED_W + 1;
	localparam int     PRW   = NEED_W + MW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_SRCH  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]         state_q;
	logic [1:0]         action_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [IDX_W-1:0]   sblock_q;
	logic [BYTES_W-1:0] held_q;

	// blocks needed
	logic [NEED_W-1:0]  dq_q;
	logic [NEED_W-1:0]  need_sum;
	logic [PRW-1:0]     quot_prod;
	logic [NEED_W-1:0]  need_calc;

	// ring walk and search state
	logic [WCW-1:0]     wc_q;
	logic [BND_W-1:0]   run_q, first_q, start_q;
	logic               found_q;
	logic [CW-1:0]      count_q;

	logic               done_q, ok_q;
	logic [IDX_W-1:0]   index_q;
	logic [BYTES_W-1:0] alloc_q;

	logic [CELL_W-1:0]  cell_q [NW];
	logic [CELL_W-1:0]  head_new;
	logic               shift;
	scan_ctl_t          ctl;
	logic [BND_W-1:0]   base;
	logic [BND_W-1:0]   run_n, first_n, start_n;
	logic               found_n;
	logic [ONES_W-1:0]  ones;
	logic               last_word;
	logic               grant;
	logic [PW-1:0]      prod;
	logic [BYTES_W:0]   held_sum;

	assign shift     = (state_q == S_SRCH) || (state_q == S_APPLY);
	assign last_word = (wc_q == WCW'(NW - 1));
	assign base      = BND_W'(wc_q) << $clog2(CELL_W);
	assign grant     = found_q && (dq_q != '0);

	// ring: each cell takes its upper neighbour; the top cell takes the scanned head word
	for (genvar i = 0; i < NW; i++) begin : g_cell
		logic [CELL_W-1:0] d;
		if (i == NW - 1) begin : g_tail
			assign d = head_new;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		bffa_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	always_comb begin
		ctl.apply = (state_q == S_APPLY);
		ctl.op    = OP_NONE;
		ctl.lo    = '0;
		case (action_q)
			ACT_ALLOC: begin
				ctl.op = found_q ? OP_SET : OP_NONE;
				ctl.lo = start_q;
			end
			ACT_FREE: begin
				ctl.op = OP_CLR;
				ctl.lo = BND_W'(sblock_q);
			end
			ACT_CLEAR: ctl.op = OP_ZERO;
			default:   ctl.op = OP_NONE;
		endcase
		ctl.hi = ctl.lo + BND_W'(dq_q);
	end

	bffa_scan #(.POOL_BLOCKS(POOL_BLOCKS)) u_scan (
		.ctl      (ctl),
		.base     (base),
		.word_in  (cell_q[0]),
		.need     (dq_q),
		.run_in   (run_q),
		.first_in (first_q),
		.found_in (found_q),
		.start_in (start_q),
		.word_out (head_new),
		.run_out  (run_n),
		.first_out(first_n),
		.found_out(found_n),
		.start_out(start_n),
		.ones     (ones)
	);

	// bytes rounded up to whole blocks
	assign need_sum  = NEED_W'(bytes_q) + NEED_W'(BLOCK_BYTES - 1);
	assign quot_prod = PRW'(need_sum) * PRW'(DIV_M);
	assign need_calc = NEED_W'(quot_prod >> DIV_S);

	assign prod     = PW'(count_q) * PW'(BLOCK_BYTES);
	assign held_sum = {1'b0, held_q} + {1'b0, bytes_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			wc_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						action_q <= action;
						bytes_q  <= request_bytes;
						sblock_q <= start_block;
						found_q  <= 1'b0;
						run_q    <= '0;
						first_q  <= '0;
						start_q  <= '0;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					dq_q    <= need_calc;
					wc_q    <= '0;
					count_q <= '0;
					if (action_q == ACT_ALLOC && need_calc != '0) begin
						state_q <= S_SRCH;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_SRCH: begin
					run_q   <= run_n;
					first_q <= first_n;
					found_q <= found_n;
					start_q <= start_n;
					wc_q    <= last_word ? '0 : wc_q + 1'b1;
					if (last_word) state_q <= S_APPLY;
				end
				S_APPLY: begin
					count_q <= count_q + CW'(ones);
					wc_q    <= last_word ? '0 : wc_q + 1'b1;
					if (last_word) state_q <= S_FIN;
				end
				S_FIN: begin
					alloc_q <= (prod > PW'(FIELD_MAX)) ? FIELD_MAX : BYTES_W'(prod);
					index_q <= '0;
					ok_q    <= 1'b1;
					if (action_q == ACT_ALLOC) begin
						if (grant) begin
							index_q <= IDX_W'(start_q);
							held_q  <= held_sum[BYTES_W] ? FIELD_MAX : held_sum[BYTES_W-1:0];
						end else if (dq_q != '0) begin
							ok_q <= 1'b0;
						end
					end else if (action_q == ACT_FREE) begin
						held_q <= (held_q > bytes_q) ? held_q - bytes_q : '0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign grant_block     = index_q;
	assign ok              = ok_q;
	assign allocated_bytes = alloc_q;
	assign requested_total = held_q;

	// a result only ever appears once the block has gone idle
	`BFFA_ASSERT_NOW(a_done_idle, done_q, !busy)
	// a failed allocate reports block zero
	`BFFA_ASSERT_NOW(a_fail_zero, done_q && !ok_q, index_q == '0)
	// an accepted request makes the block busy
	`BFFA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// the ring walk is word-aligned whenever a pass begins or the block idles
	`BFFA_ASSERT_NOW(a_ring_align, state_q == S_IDLE || state_q == S_DIV, wc_q == '0)
endmodule

// ----- sv/bffa_cell.sv -----
// One cell of the use-map ring: a word of map bits handed on each shift.
// Depends on bffa_pkg.
module bffa_cell import bffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [CELL_W-1:0] d,
	output logic [CELL_W-1:0] q
);
	logic [CELL_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;
endmodule

// ----- sv/bffa_scan.sv -----
// Head-of-ring word processor: first-fit run search and range set/clear/zero with bit count.
// Depends on bffa_pkg.
module bffa_scan import bffa_pkg::*; #(
	parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
	input  scan_ctl_t         ctl,
	input  logic [BND_W-1:0]  base,
	input  logic [CELL_W-1:0] word_in,
	input  logic [NEED_W-1:0] need,
	input  logic [BND_W-1:0]  run_in,
	input  logic [BND_W-1:0]  first_in,
	input  logic              found_in,
	input  logic [BND_W-1:0]  start_in,
	output logic [CELL_W-1:0] word_out,
	output logic [BND_W-1:0]  run_out,
	output logic [BND_W-1:0]  first_out,
	output logic              found_out,
	output logic [BND_W-1:0]  start_out,
	output logic [ONES_W-1:0] ones
);
	always_comb begin
		logic [BND_W-1:0] g;
		logic used;
		logic inr;
		run_out   = run_in;
		first_out = first_in;
		found_out = found_in;
		start_out = start_in;
		word_out  = word_in;
		ones      = '0;
		for (int b = 0; b < CELL_W; b++) begin
			g    = base + BND_W'(b);
			used = word_in[b] || (g >= BND_W'(POOL_BLOCKS));
			inr  = (g >= ctl.lo) && (g < ctl.hi);
			if (!ctl.apply) begin
				if (!found_out) begin
					if (used) begin
						run_out = '0;
					end else begin
						if (run_out == '0) first_out = g;
						run_out = run_out + 1'b1;
						if (run_out >= BND_W'(need)) begin
							found_out = 1'b1;
							start_out = first_out;
						end
					end
				end
			end else begin
				case (ctl.op)
					OP_SET:  word_out[b] = word_in[b] | inr;
					OP_CLR:  word_out[b] = word_in[b] & ~inr;
					OP_ZERO: word_out[b] = 1'b0;
					default: word_out[b] = word_in[b];
				endcase
			end
			ones = ones + ONES_W'(word_out[b]);
		end
	end
endmodule
